[src/itoa_pkg.sv]
`default_nettype none

package itoa_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int BASE_W      = 6;
	localparam int CHAR_W      = 7;
	localparam int DIGIT_W     = 6;

	// Quotient bits resolved per cycle; VALUE_WIDTH must be a multiple of it.
	localparam int STEP_BITS  = 4;
	localparam int DIV_STEPS  = VALUE_WIDTH / STEP_BITS;
	localparam int STEP_CNT_W = $clog2(DIV_STEPS);
	localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);
	localparam int IDX_W      = $clog2(VALUE_WIDTH);

	localparam logic [BASE_W-1:0]  MIN_BASE   = BASE_W'(2);
	localparam logic [BASE_W-1:0]  MAX_BASE   = BASE_W'(36);
	localparam logic [DIGIT_W-1:0] MAX_DIGIT  = DIGIT_W'(35);
	localparam logic [DIGIT_W-1:0] TEN        = DIGIT_W'(10);
	localparam logic [CHAR_W-1:0]  CHAR_MINUS = 7'h2d;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0]  CHAR_LOW_A = 7'h61;
	localparam logic [CHAR_W-1:0]  CHAR_NONE  = 7'h00;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BAD,
		ST_DIV,
		ST_SIGN,
		ST_EMIT
	} itoa_state_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [DIGIT_W-1:0] c;
		c = (d > MAX_DIGIT) ? MAX_DIGIT : d;
		if (c < TEN) begin
			return CHAR_ZERO + CHAR_W'(c);
		end
		return CHAR_LOW_A + CHAR_W'(c - TEN);
	endfunction

endpackage

`default_nettype wire

[src/itoa_if.sv]
`default_nettype none

interface itoa_in_if import itoa_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;
	logic        [BASE_W-1:0]      base;

	modport source (output valid, output value, output base, input ready);
	modport sink (input valid, input value, input base, output ready);
endinterface

interface itoa_out_if import itoa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              last_char;
	logic              bad_base;

	modport source (output valid, output char_code, output last_char, output bad_base,
		input ready);
	modport sink (input valid, input char_code, input last_char, input bad_base,
		output ready);
endinterface

`default_nettype wire

[src/integer_to_base_n_ascii_top.sv]
// Integer to base-N ASCII converter.
// in_ch carries a signed value and a base; out_ch returns one ASCII character
// per word, most significant first, with last_char on the final one. A
// negative value starts with '-'. A base outside 2..36 returns a single word
// with bad_base and last_char set and char_code 0.
// Each digit comes from a shared restoring divider that resolves four
// quotient bits per cycle. The divider runs once per digit for a value with
// D digits (D <= 32), then the sign and digits leave at one word per cycle
// from the output register while out_ch.ready stays high.
// in_ch.ready is high only while the block is idle; an item may be taken
// while the final character of the previous one still waits in the output
// register. When out_ch.ready is low a pending output word holds and the
// emitting states wait. Reset clears the sequencer and the output valid; the
// digit buffer is not cleared and is always written before it is read.
`default_nettype none

module integer_to_base_n_ascii_top import itoa_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	itoa_in_if.sink    in_ch,
	itoa_out_if.source out_ch
);

	itoa_state_t state_q, state_d;

	logic [VALUE_WIDTH-1:0] quo_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic [BASE_W-1:0]      radix_q;
	logic                   neg_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [STEP_CNT_W-1:0]  step_q;
	logic [DIGIT_W-1:0]     buf_q [VALUE_WIDTH];

	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_last_q;
	logic              out_bad_q;

	logic                   start;
	logic                   bad_in;
	logic                   out_free;
	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] mag;
	logic [VALUE_WIDTH-1:0] div_q;
	logic [DIGIT_W-1:0]     div_r;
	logic                   digit_done;
	logic                   div_end;
	logic [CNT_W-1:0]       cnt_dec;
	logic [DIGIT_W-1:0]     rd_digit;

	logic              load_out;
	logic [CHAR_W-1:0] load_char;
	logic              load_last;
	logic              load_bad;
	logic              emit_dec;

	assign raw      = in_ch.value;
	assign mag      = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
	assign bad_in   = (in_ch.base < MIN_BASE) || (in_ch.base > MAX_BASE);
	assign start    = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign cnt_dec  = cnt_q - 1'b1;
	assign rd_digit = buf_q[cnt_dec[IDX_W-1:0]];

	// restoring division, STEP_BITS quotient bits per cycle
	always_comb begin
		logic [DIGIT_W:0] t;
		logic [VALUE_WIDTH-1:0] q;
		logic [DIGIT_W-1:0] r;
		q = quo_q;
		r = rem_q;
		for (int i = 0; i < STEP_BITS; i++) begin
			t = {r, q[VALUE_WIDTH-1]};
			q = {q[VALUE_WIDTH-2:0], 1'b0};
			if (t >= {1'b0, radix_q}) begin
				t = t - {1'b0, radix_q};
				q[0] = 1'b1;
			end
			r = t[DIGIT_W-1:0];
		end
		div_q = q;
		div_r = r;
	end

	assign digit_done = (step_q == STEP_CNT_W'(DIV_STEPS - 1));
	assign div_end    = digit_done &&
		((div_q == '0) || (cnt_q == CNT_W'(VALUE_WIDTH - 1)));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = bad_in ? ST_BAD : ST_DIV;
				end
			end
			ST_BAD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (div_end) begin
					state_d = neg_q ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (out_free) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free && (cnt_q == CNT_W'(1))) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = 1'b0;
		load_out    = 1'b0;
		load_char   = CHAR_NONE;
		load_last   = 1'b0;
		load_bad    = 1'b0;
		emit_dec    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
			end
			ST_BAD: begin
				load_out  = out_free;
				load_char = CHAR_NONE;
				load_last = 1'b1;
				load_bad  = 1'b1;
			end
			ST_DIV: begin
			end
			ST_SIGN: begin
				load_out  = out_free;
				load_char = CHAR_MINUS;
			end
			ST_EMIT: begin
				load_out  = out_free;
				load_char = digit_char(rd_digit);
				load_last = (cnt_q == CNT_W'(1));
				emit_dec  = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			step_q  <= '0;
			quo_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start && !bad_in) begin
				quo_q  <= mag;
				neg_q  <= raw[VALUE_WIDTH-1];
				cnt_q  <= '0;
				step_q <= '0;
			end else if (state_q == ST_DIV) begin
				quo_q <= div_q;
				if (digit_done) begin
					step_q <= '0;
					cnt_q  <= cnt_q + 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end else if (emit_dec) begin
				cnt_q <= cnt_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !bad_in) begin
			rem_q   <= '0;
			radix_q <= in_ch.base;
		end else if (state_q == ST_DIV) begin
			rem_q <= digit_done ? '0 : div_r;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV) && digit_done) begin
			buf_q[cnt_q[IDX_W-1:0]] <= div_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_char_q <= load_char;
			out_last_q <= load_last;
			out_bad_q  <= load_bad;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.char_code = out_char_q;
	assign out_ch.last_char = out_last_q;
	assign out_ch.bad_base  = out_bad_q;

endmodule

`default_nettype wire

[src/itoa_checker.sv]
`default_nettype none

module itoa_checker import itoa_pkg::*; (
	input wire              clk,
	input wire              arst_n,
	input wire              in_valid,
	input wire              in_ready,
	input wire              out_valid,
	input wire              out_ready,
	input wire [CHAR_W-1:0] out_char,
	input wire              out_last,
	input wire              out_bad
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char))
		else $error("output word dropped or changed while stalled");

	a_bad_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_bad |-> out_last && (out_char == CHAR_NONE))
		else $error("bad base word malformed");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_char == CHAR_MINUS) |-> !out_last)
		else $error("sign emitted as final character");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again before conversion finished");

endmodule

bind integer_to_base_n_ascii_top itoa_checker u_itoa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_char  (out_ch.char_code),
	.out_last  (out_ch.last_char),
	.out_bad   (out_ch.bad_base)
);

`default_nettype wire

[bench/tb_integer_to_base_n_ascii_top.sv]
`timescale 1ns / 1ps

module tb_integer_to_base_n_ascii_top;
	import itoa_pkg::*;

	localparam int RANDOM_ITEMS   = 250;
	localparam int TAIL_ITEMS     = 40;
	localparam int HOLD_START     = 3000;
	localparam int HOLD_CYCLES    = 600;
	localparam int SETTLE_CYCLES  = 320;
	localparam int WATCHDOG_LIMIT = 5000;

	localparam logic [VALUE_WIDTH-1:0] MOST_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam logic [VALUE_WIDTH-1:0] MOST_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam string GLYPHS = "0123456789abcdefghijklmnopqrstuvwxyz";

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] value;
		logic        [BASE_W-1:0]      base;
	} conv_req_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last_char;
		logic              bad_base;
	} char_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	itoa_in_if  in_ch ();
	itoa_out_if out_ch ();

	integer_to_base_n_ascii_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	always #6 clk = ~clk;

	conv_req_t  req_queue[$];
	char_word_t text_queue[$];
	conv_req_t  next_req;
	int         total_reqs;
	int         reqs_taken;
	int         chars_checked;
	int         bad_base_reqs;
	int         errors;
	int         gap_left;
	int         stall_left;
	int         hold_left;
	int         rx_cycles;
	int         quiet_cycles;
	logic       held_once;
	logic       tail_mode;

	task automatic add_req(input logic signed [VALUE_WIDTH-1:0] value,
		input logic [BASE_W-1:0] base);
		conv_req_t r;
		r.value = value;
		r.base  = base;
		req_queue.push_back(r);
	endtask

	// Expected text of one conversion, pushed most significant character first.
	task automatic predict_text(input logic signed [VALUE_WIDTH-1:0] value,
		input logic [BASE_W-1:0] base);
		logic [VALUE_WIDTH-1:0] magnitude;
		logic [DIGIT_W-1:0]     digit_buf[VALUE_WIDTH];
		char_word_t             w;
		int                     n;
		int                     d;
		if (base < MIN_BASE || base > MAX_BASE) begin
			w.char_code = CHAR_NONE;
			w.last_char = 1'b1;
			w.bad_base  = 1'b1;
			text_queue.push_back(w);
			bad_base_reqs++;
		end else begin
			magnitude = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
			if (value[VALUE_WIDTH-1]) begin
				w.char_code = CHAR_MINUS;
				w.last_char = 1'b0;
				w.bad_base  = 1'b0;
				text_queue.push_back(w);
			end
			n = 0;
			do begin
				digit_buf[n] = DIGIT_W'(magnitude % VALUE_WIDTH'(base));
				magnitude    = magnitude / VALUE_WIDTH'(base);
				n++;
			end while (magnitude != 0 && n < VALUE_WIDTH);
			for (int i = n - 1; i >= 0; i--) begin
				d = (digit_buf[i] > MAX_DIGIT) ? int'(MAX_DIGIT) : int'(digit_buf[i]);
				w.char_code = CHAR_W'(GLYPHS[d]);
				w.last_char = (i == 0);
				w.bad_base  = 1'b0;
				text_queue.push_back(w);
			end
		end
	endtask

	task automatic check_word();
		char_word_t exp;
		if (text_queue.size() == 0) begin
			$display("%0t: unexpected word char_code=%h last_char=%b bad_base=%b", $time,
				out_ch.char_code, out_ch.last_char, out_ch.bad_base);
			errors++;
		end else begin
			exp = text_queue.pop_front();
			chars_checked++;
			if (out_ch.char_code !== exp.char_code) begin
				$display("%0t: char_code expected %h actual %h", $time, exp.char_code,
					out_ch.char_code);
				errors++;
			end
			if (out_ch.last_char !== exp.last_char) begin
				$display("%0t: last_char expected %b actual %b", $time, exp.last_char,
					out_ch.last_char);
				errors++;
			end
			if (out_ch.bad_base !== exp.bad_base) begin
				$display("%0t: bad_base expected %b actual %b", $time, exp.bad_base,
					out_ch.bad_base);
				errors++;
			end
		end
	endtask

	function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
		logic [VALUE_WIDTH-1:0] v;
		case ($urandom_range(0, 5))
			0, 1: v = $urandom;
			2: begin
				v = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(0, 1) == 1) v = -v;
			end
			3: begin
				v = $urandom_range(0, 40);
				if ($urandom_range(0, 1) == 1) v = -v;
			end
			4: begin
				case ($urandom_range(0, 3))
					0: v = MOST_NEG;
					1: v = MOST_POS;
					2: v = '1;
					default: v = '0;
				endcase
			end
			default: v = $urandom | MOST_NEG;
		endcase
		return v;
	endfunction

	function automatic logic [BASE_W-1:0] pick_base();
		case ($urandom_range(0, 19))
			0: return BASE_W'($urandom_range(0, 1));
			1: return BASE_W'($urandom_range(int'(MAX_BASE) + 1, (1 << BASE_W) - 1));
			2: return MIN_BASE;
			3: return MAX_BASE;
			default: return BASE_W'($urandom_range(int'(MIN_BASE), int'(MAX_BASE)));
		endcase
	endfunction

	// sender: hold the word until taken, idle in bursts outside the tail
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.value <= '0;
			in_ch.base  <= '0;
			gap_left    <= 0;
			tail_mode   <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_text(in_ch.value, in_ch.base);
				reqs_taken++;
			end
			tail_mode <= (req_queue.size() < TAIL_ITEMS);
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left != 0) begin
					gap_left    <= gap_left - 1;
					in_ch.valid <= 1'b0;
				end else if (!tail_mode && hold_left == 0 && $urandom_range(0, 7) == 0) begin
					gap_left    <= $urandom_range(0, 11);
					in_ch.valid <= 1'b0;
				end else if (req_queue.size() != 0) begin
					next_req    = req_queue.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.value <= next_req.value;
					in_ch.base  <= next_req.base;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: check each word, stall in bursts, hold off once for a long stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left   <= 0;
			hold_left    <= 0;
			held_once    <= 1'b0;
			rx_cycles    <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) check_word();
			rx_cycles <= rx_cycles + 1;
			if (!held_once && rx_cycles >= HOLD_START) begin
				held_once    <= 1'b1;
				hold_left    <= HOLD_CYCLES;
				out_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left    <= hold_left - 1;
				out_ch.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left   <= stall_left - 1;
				out_ch.ready <= 1'b0;
			end else if (!tail_mode && $urandom_range(0, 7) == 0) begin
				stall_left   <= $urandom_range(0, 11);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
				$display("tb_integer_to_base_n_ascii_top: done, errors");
				$finish;
			end
		end
	end

	initial begin
		in_ch.valid   = 1'b0;
		in_ch.value   = '0;
		in_ch.base    = '0;
		out_ch.ready  = 1'b0;
		reqs_taken    = 0;
		chars_checked = 0;
		bad_base_reqs = 0;
		errors        = 0;
		quiet_cycles  = 0;

		add_req(0, 10);
		add_req(0, MIN_BASE);
		add_req(0, MAX_BASE);
		add_req(MOST_POS, MIN_BASE);
		add_req(MOST_POS, MAX_BASE);
		add_req(MOST_NEG, MIN_BASE);
		add_req(MOST_NEG, 10);
		add_req(MOST_NEG, 16);
		add_req(MOST_NEG, MAX_BASE);
		add_req(-1, MIN_BASE);
		add_req(-1, MAX_BASE);
		add_req(1, MIN_BASE);
		add_req(35, MAX_BASE);
		add_req(36, MAX_BASE);
		add_req(-35, MAX_BASE);
		add_req(255, 16);
		add_req(-123456789, 10);
		add_req(1162261467, 3);
		add_req(7, 35);
		add_req(1, 0);
		add_req(1, 1);
		add_req(-5, MAX_BASE + 1'b1);
		add_req(12345, 63);
		for (int i = 0; i < RANDOM_ITEMS; i++) add_req(pick_value(), pick_base());
		total_reqs = req_queue.size();

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait (reqs_taken == total_reqs);
		while (text_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("converted %0d values (%0d with a bad base), %0d characters checked",
			reqs_taken, bad_base_reqs, chars_checked);
		$display("receiver held off %0d cycles once; %0d mismatches", HOLD_CYCLES, errors);
		if (errors == 0 && text_queue.size() == 0) begin
			$display("tb_integer_to_base_n_ascii_top: done, clean");
		end else begin
			$display("tb_integer_to_base_n_ascii_top: done, errors");
		end
		$finish;
	end

endmodule

[integer_to_base_n_ascii_top.f]
src/itoa_pkg.sv
src/itoa_if.sv
src/integer_to_base_n_ascii_top.sv
src/itoa_checker.sv
bench/tb_integer_to_base_n_ascii_top.sv
